// ----- hdl/cdseg_pkg.sv -----
package cdseg_pkg;

    localparam int MIN_W   = 7;
    localparam int SEC_W   = 6;
    localparam int MS_W    = 10;
    localparam int SCAN_W  = 2;
    localparam int SEG_W   = 7;
    localparam int PORT_W  = 12;
    localparam int CFG_W   = 10;
    localparam int BCD_W   = 4;

    localparam logic [MIN_W-1:0]  START_MINUTES_RST = MIN_W'(24);
    localparam logic [MS_W-1:0]   MS_RELOAD_RST     = MS_W'(999);
    localparam logic [SEC_W-1:0]  SEC_RELOAD        = SEC_W'(59);
    localparam logic [SEG_W-1:0]  SEG_ALL_ON        = SEG_W'(8'h7f);

    localparam logic [SCAN_W-1:0] DIGIT_UNITS     = 2'd0;
    localparam logic [SCAN_W-1:0] DIGIT_TENS      = 2'd1;
    localparam logic [SCAN_W-1:0] DIGIT_HUNDREDS  = 2'd2;
    localparam logic [SCAN_W-1:0] DIGIT_THOUSANDS = 2'd3;

    typedef enum logic [0:0] {
        CFG_START_MINUTES = 1'b0,
        CFG_MS_RELOAD     = 1'b1
    } cfg_index_t;

    // quotient by ten via reciprocal multiply, exact for 0..127
    function automatic logic [BCD_W-1:0] div10(input logic [MIN_W-1:0] x);
        logic [14:0] prod;
        prod = 15'(x) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [BCD_W-1:0] mod10(input logic [MIN_W-1:0] x);
        logic [MIN_W-1:0] rem;
        rem = x - MIN_W'(div10(x)) * MIN_W'(10);
        return rem[BCD_W-1:0];
    endfunction

    function automatic logic [SEG_W-1:0] seg_decode(input logic [BCD_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = 7'h3f;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/countdown_seven_segment_scan_top.sv -----
// Channel  Direction  Handshake                  Payload
// in       input      in_valid / in_ready        restart
// out      output     out_valid / out_ready      port_word, digit_index, segments, expired
// cfg      input      cfg_we (no handshake back) cfg_index, cfg_data
//
// One word per cycle while the output register drains: counters update and the digit is
// decoded in the accepting cycle, the result word sits in the output register from the next cycle.
// in_ready is high while the output register is empty or being emptied.
// Reset clears counters (minutes to 24), scan to units, output register empty.
// A stall on out holds the result word; in stalls only while it is held.
module countdown_seven_segment_scan_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  cdseg_pkg::cfg_index_t         cfg_index,
    input  logic [cdseg_pkg::CFG_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cdseg_pkg::PORT_W-1:0]  port_word,
    output logic [cdseg_pkg::SCAN_W-1:0]  digit_index,
    output logic [cdseg_pkg::SEG_W-1:0]   segments,
    output logic                          expired
);
    import cdseg_pkg::*;

    logic [MIN_W-1:0]  start_min_reg;
    logic [MS_W-1:0]   ms_reload_reg;
    logic [MS_W-1:0]   ms_reg,   ms_next;
    logic [SEC_W-1:0]  sec_reg,  sec_next;
    logic [MIN_W-1:0]  min_reg,  min_next;
    logic [SCAN_W-1:0] scan_reg;
    logic              out_valid_reg;
    logic [PORT_W-1:0] port_reg;
    logic [SCAN_W-1:0] digit_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic              expired_reg;

    logic              accept;
    logic              expired_next;
    logic [BCD_W-1:0]  digit_val;
    logic [SEG_W-1:0]  seg_next;
    logic [3:0]        enables;
    logic [MIN_W-1:0]  sec_wide;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg <= START_MINUTES_RST;
            ms_reload_reg <= MS_RELOAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_MINUTES: start_min_reg <= cfg_data[MIN_W-1:0];
                CFG_MS_RELOAD:     ms_reload_reg <= cfg_data[MS_W-1:0];
                default:           ;
            endcase
        end
    end

    // counter update
    always_comb
    begin
        ms_next  = ms_reg;
        sec_next = sec_reg;
        min_next = min_reg;
        if (restart)
        begin
            ms_next  = '0;
            sec_next = '0;
            min_next = start_min_reg;
        end
        else if (min_reg != '0)
        begin
            if (ms_reg <= MS_W'(1))
            begin
                ms_next = ms_reload_reg;
                if (sec_reg <= SEC_W'(1))
                begin
                    sec_next = SEC_RELOAD;
                    min_next = min_reg - MIN_W'(1);
                end
                else
                begin
                    sec_next = sec_reg - SEC_W'(1);
                end
            end
            else
            begin
                ms_next = ms_reg - MS_W'(1);
            end
        end
    end

    // digit decode; seconds stay below 100 so no carry into minutes digits
    always_comb
    begin
        sec_wide     = MIN_W'(sec_next);
        expired_next = (min_next == '0);
        case (scan_reg)
            DIGIT_UNITS:     digit_val = mod10(sec_wide);
            DIGIT_TENS:      digit_val = div10(sec_wide);
            DIGIT_HUNDREDS:  digit_val = mod10(min_next);
            DIGIT_THOUSANDS: digit_val = mod10(MIN_W'(div10(min_next)));
            default:         digit_val = '0;
        endcase
        seg_next = expired_next ? SEG_ALL_ON : seg_decode(digit_val);
        enables  = 4'b1111;
        enables[SCAN_W'(3) - scan_reg] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg        <= '0;
            sec_reg       <= '0;
            min_reg       <= START_MINUTES_RST;
            scan_reg      <= DIGIT_UNITS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ms_reg   <= ms_next;
                sec_reg  <= sec_next;
                min_reg  <= min_next;
                scan_reg <= scan_reg + SCAN_W'(1);
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            port_reg    <= {seg_next, enables, 1'b0};
            digit_reg   <= scan_reg;
            seg_reg     <= seg_next;
            expired_reg <= expired_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign port_word   = port_reg;
    assign digit_index = digit_reg;
    assign segments    = seg_reg;
    assign expired     = expired_reg;

endmodule

// ----- test/countdown_seven_segment_scan_top_tb.sv -----
`timescale 1ns / 100ps

module countdown_seven_segment_scan_top_tb;

    import cdseg_pkg::*;

    typedef struct packed {
        logic [PORT_W-1:0] port_word;
        logic [SCAN_W-1:0] digit_index;
        logic [SEG_W-1:0]  segments;
        logic              expired;
    } scan_word_t;

    class scan_checker;
        logic [MIN_W-1:0]  start_min;
        logic [MS_W-1:0]   ms_reload;
        logic [MS_W-1:0]   ms_left;
        logic [SEC_W-1:0]  sec_left;
        logic [MIN_W-1:0]  min_left;
        logic [SCAN_W-1:0] scan_pos;
        logic [SEG_W-1:0]  digit_glyph [10];
        scan_word_t        expected_words [$];
        int                mismatches;

        function new();
            digit_glyph = '{7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66,
                            7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f};
            start_min  = 7'd24;
            ms_reload  = 10'd999;
            ms_left    = '0;
            sec_left   = '0;
            min_left   = 7'd24;
            scan_pos   = DIGIT_UNITS;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            if (idx == CFG_START_MINUTES)
                start_min = val[MIN_W-1:0];
            else
                ms_reload = val[MS_W-1:0];
        endfunction

        // counter update, then the digit under the scan
        function void accept_tick(logic restart_bit);
            int unsigned shown;
            scan_word_t  w;
            if (restart_bit)
            begin
                ms_left  = '0;
                sec_left = '0;
                min_left = start_min;
            end
            else if (min_left != 0)
            begin
                if (ms_left <= 1)
                begin
                    ms_left = ms_reload;
                    if (sec_left <= 1)
                    begin
                        sec_left = 6'd59;
                        min_left = min_left - 1'b1;
                    end
                    else
                        sec_left = sec_left - 1'b1;
                end
                else
                    ms_left = ms_left - 1'b1;
            end
            w.expired = (min_left == 0);
            shown = w.expired ? 8888 : min_left * 100 + sec_left;
            for (int k = 0; k < scan_pos; k++)
                shown = shown / 10;
            w.segments    = digit_glyph[shown % 10];
            w.digit_index = scan_pos;
            w.port_word   = 12'h01e;
            w.port_word[4 - scan_pos] = 1'b0;
            w.port_word[11:5] = w.segments;
            expected_words.push_back(w);
            scan_pos = scan_pos + 1'b1;
        endfunction

        function void check_word(scan_word_t got);
            scan_word_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word port %h idx %0d seg %h exp %0b",
                             $time, got.port_word, got.digit_index, got.segments,
                             got.expired);
                return;
            end
            want = expected_words.pop_front();
            if (got.port_word !== want.port_word || got.digit_index !== want.digit_index ||
                got.segments !== want.segments || got.expired !== want.expired)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: word differs: expected port %h idx %0d seg %h exp %0b",
                             $time, want.port_word, want.digit_index, want.segments,
                             want.expired);
                    $display("%0t: word differs: got      port %h idx %0d seg %h exp %0b",
                             $time, got.port_word, got.digit_index, got.segments,
                             got.expired);
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_index_t        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              restart;
    logic              out_valid;
    logic              out_ready;
    logic [PORT_W-1:0] port_word;
    logic [SCAN_W-1:0] digit_index;
    logic [SEG_W-1:0]  segments;
    logic              expired;

    scan_checker sb = new();
    bit          steady;
    bit          hold_req;

    countdown_seven_segment_scan_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .port_word   (port_word),
        .digit_index (digit_index),
        .segments    (segments),
        .expired     (expired)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.accept_tick(restart);
        if (rst_n && out_valid && out_ready)
            sb.check_word('{port_word, digit_index, segments, expired});
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (60) @(posedge clk);
            end
            else
                out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
        end
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_tick(logic r);
        if (!steady && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_words.size() != 0);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setting(logic [CFG_W-1:0] mins, logic [CFG_W-1:0] reload);
        settle();
        repeat (4) @(posedge clk);
        write_reg(CFG_START_MINUTES, mins);
        write_reg(CFG_MS_RELOAD, reload);
    endtask

    task automatic count_words(int n_words, int hold_at, int pause_at);
        send_tick(1'b1);
        for (int i = 0; i < n_words; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
                settle();
            send_tick($urandom_range(0, 99) < 2);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_START_MINUTES;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        steady    = 1'b0;
        hold_req  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: first tick borrows a minute
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        // zero minutes: expired from restart, ticks change nothing
        load_setting(10'd0, 10'd1023);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        // minutes above 99, zero reload: thousands digit wraps, second per tick
        load_setting(10'd127, 10'd0);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        load_setting(10'd99, 10'd1);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);

        load_setting(10'd1, 10'd0);
        count_words(170, -1, -1);
        load_setting(10'd2, 10'd1);
        count_words(170, 50, -1);
        load_setting(10'd3, 10'd0);
        steady = 1'b1;
        count_words(170, -1, -1);
        steady = 1'b0;
        load_setting(10'd99, 10'd1023);
        count_words(170, -1, 100);
        load_setting(10'($urandom_range(0, 3)), 10'($urandom_range(0, 3)));
        count_words(170, 120, -1);
        load_setting(10'd2, 10'd2);
        count_words(170, -1, -1);

        settle();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/cdseg_pkg.sv
hdl/countdown_seven_segment_scan_top.sv
test/countdown_seven_segment_scan_top_tb.sv
